>>> rtl/acs_pkg.sv
// Shared types, codes and helper functions for the alarm clock controller.
package acs_pkg;

    typedef enum logic [2:0] {
        FN_TICK    = 3'd0,
        FN_PRESS   = 3'd1,
        FN_RELEASE = 3'd2,
        FN_RTC     = 3'd3,
        FN_TEMP    = 3'd4
    } t_func;

    localparam logic [1:0] KEY_SET_CLOCK = 2'd0;
    localparam logic [1:0] KEY_SET_ALARM = 2'd1;
    localparam logic [1:0] KEY_UP        = 2'd2;
    localparam logic [1:0] KEY_DOWN      = 2'd3;

    localparam logic [1:0] FLD_NONE   = 2'd0;
    localparam logic [1:0] FLD_HOUR   = 2'd1;
    localparam logic [1:0] FLD_MINUTE = 2'd2;
    localparam logic [1:0] FLD_SECOND = 2'd3;

    localparam logic [1:0] CFG_SCAN_DIV   = 2'd0;
    localparam logic [1:0] CFG_BLINK      = 2'd1;
    localparam logic [1:0] CFG_ALARM_HALF = 2'd2;
    localparam logic [1:0] CFG_ALARM_TOGS = 2'd3;

    localparam int unsigned CFG_W = 16;

    localparam logic [7:0] SEG_DASH  = 8'hbf;
    localparam logic [7:0] SEG_BLANK = 8'hff;
    localparam logic [7:0] SEG_C     = 8'hc6;

    localparam logic [5:0] HOUR_MAX = 6'd23;
    localparam logic [5:0] MIN_MAX  = 6'd59;

    typedef logic [2:0][5:0] t_time;

    // Context the display decoder needs for one digit.
    typedef struct packed {
        logic [1:0] clock_field;
        logic [1:0] alarm_field;
        logic       temp_view;
        logic       blink_on;
        t_time      edit_time;
        t_time      alarm_time;
        t_time      now_time;
        logic [6:0] temp_value;
        logic [2:0] pos;
    } t_disp_ctx;

    typedef struct packed {
        logic       scan_valid;
        logic [2:0] digit_index;
        logic [7:0] segments;
        logic       alarm_led;
        logic       rtc_write;
        logic [4:0] new_hour;
        logic [5:0] new_minute;
        logic [5:0] new_second;
    } t_result;

    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'd0:    s = 8'hc0;
            4'd1:    s = 8'hf9;
            4'd2:    s = 8'ha4;
            4'd3:    s = 8'hb0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hf8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h90;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    // Tens digit of a value below 100, by a chain of compares.
    function automatic logic [3:0] tens_of(input logic [6:0] v);
        logic [3:0] t;
        t = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (v >= 7'(k * 10)) t = 4'(k);
        end
        return t;
    endfunction

    function automatic logic [3:0] ones_of(input logic [6:0] v);
        logic [6:0] r;
        r = v - 7'(tens_of(v) * 4'd10);
        return r[3:0];
    endfunction

endpackage

>>> rtl/acs_in_if.sv
// Input channel carrying one event item.
interface acs_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [1:0] key_code;
    logic [4:0] rtc_hour;
    logic [5:0] rtc_minute;
    logic [5:0] rtc_second;
    logic [6:0] temp_reading;

    modport source (output valid, func, key_code, rtc_hour, rtc_minute, rtc_second,
                    temp_reading, input ready);
    modport sink (input valid, func, key_code, rtc_hour, rtc_minute, rtc_second,
                  temp_reading, output ready);
endinterface

>>> rtl/acs_out_if.sv
// Output channel carrying one result item.
interface acs_out_if;
    logic       valid;
    logic       ready;
    logic       scan_valid;
    logic [2:0] digit_index;
    logic [7:0] segments;
    logic       alarm_led;
    logic       rtc_write;
    logic [4:0] new_hour;
    logic [5:0] new_minute;
    logic [5:0] new_second;

    modport source (output valid, scan_valid, digit_index, segments, alarm_led, rtc_write,
                    new_hour, new_minute, new_second, input ready);
    modport sink (input valid, scan_valid, digit_index, segments, alarm_led, rtc_write,
                  new_hour, new_minute, new_second, output ready);
endinterface

>>> rtl/alarm_clock_set_and_display.sv
// Top level of the alarm clock controller with its result register.
//
// Each event item (tick, key press or release, RTC sample, temperature
// sample) gives exactly one result item. An item is taken in every cycle in
// which the result register is empty or being emptied, so the block sustains
// one item per clock; the result is registered and appears in the cycle after acceptance. The
// state update and digit decode for an item are done in the accepting cycle,
// and the result register holds the answer while the output side stalls.
// Configuration writes take effect at the next edge and should be made only
// while the block is idle.
module alarm_clock_set_and_display
    import acs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    acs_in_if.sink           i_in,
    acs_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic    w_accept;
    t_result w_result;
    logic    r_out_valid;
    t_result r_out;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    acs_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_func         (i_in.func),
        .i_key_code     (i_in.key_code),
        .i_rtc_hour     (i_in.rtc_hour),
        .i_rtc_minute   (i_in.rtc_minute),
        .i_rtc_second   (i_in.rtc_second),
        .i_temp_reading (i_in.temp_reading),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_result       (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.scan_valid  = r_out.scan_valid;
    assign o_out.digit_index = r_out.digit_index;
    assign o_out.segments    = r_out.segments;
    assign o_out.alarm_led   = r_out.alarm_led;
    assign o_out.rtc_write   = r_out.rtc_write;
    assign o_out.new_hour    = r_out.new_hour;
    assign o_out.new_minute  = r_out.new_minute;
    assign o_out.new_second  = r_out.new_second;

    a_blank_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.scan_valid |-> r_out.segments == SEG_BLANK)
        else $error("idle result carries a segment pattern");

    a_write_not_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.rtc_write |-> !r_out.scan_valid)
        else $error("RTC write and digit scan in one item");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted item left no result");

endmodule

>>> rtl/acs_disp.sv
// Seven-segment pattern for one scanned digit.
module acs_disp
    import acs_pkg::*;
(
    input  t_disp_ctx  i_ctx,
    output logic [7:0] o_segments
);

    logic [1:0] w_grp;
    logic [1:0] w_sub;
    logic [1:0] w_field;
    logic [1:0] w_fidx;
    t_time      w_src;
    logic [5:0] w_val;
    logic [6:0] w_temp;
    logic [7:0] w_time_seg;

    always_comb begin
        unique case (i_ctx.pos)
            3'd0: begin w_grp = 2'd0; w_sub = 2'd0; end
            3'd1: begin w_grp = 2'd0; w_sub = 2'd1; end
            3'd2: begin w_grp = 2'd0; w_sub = 2'd2; end
            3'd3: begin w_grp = 2'd1; w_sub = 2'd0; end
            3'd4: begin w_grp = 2'd1; w_sub = 2'd1; end
            3'd5: begin w_grp = 2'd1; w_sub = 2'd2; end
            3'd6: begin w_grp = 2'd2; w_sub = 2'd0; end
            default: begin w_grp = 2'd2; w_sub = 2'd1; end
        endcase
    end

    assign w_field = (i_ctx.clock_field != FLD_NONE) ? i_ctx.clock_field : i_ctx.alarm_field;
    assign w_fidx  = w_field - 2'd1;
    assign w_src   = (i_ctx.clock_field != FLD_NONE) ? i_ctx.edit_time :
                     (i_ctx.alarm_field != FLD_NONE) ? i_ctx.alarm_time : i_ctx.now_time;
    assign w_val   = w_src[w_grp];
    assign w_temp  = (i_ctx.temp_value > 7'd99) ? 7'd99 : i_ctx.temp_value;

    always_comb begin
        if (w_sub == 2'd2) begin
            w_time_seg = SEG_DASH;
        end else if (w_sub == 2'd0) begin
            w_time_seg = seg_of(tens_of({1'b0, w_val}));
        end else begin
            w_time_seg = seg_of(ones_of({1'b0, w_val}));
        end
    end

    always_comb begin
        if (w_field != FLD_NONE && i_ctx.blink_on && w_grp == w_fidx && w_sub != 2'd2) begin
            o_segments = SEG_BLANK;
        end else if (i_ctx.clock_field != FLD_NONE || i_ctx.alarm_field != FLD_NONE
                     || !i_ctx.temp_view) begin
            o_segments = w_time_seg;
        end else if (i_ctx.pos == 3'd5) begin
            o_segments = seg_of(tens_of(w_temp));
        end else if (i_ctx.pos == 3'd6) begin
            o_segments = seg_of(ones_of(w_temp));
        end else if (i_ctx.pos == 3'd7) begin
            o_segments = SEG_C;
        end else begin
            o_segments = SEG_BLANK;
        end
    end

endmodule

>>> rtl/acs_core.sv
// Controller state: key handling, scan and blink timing, alarm flasher.
module acs_core
    import acs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [2:0]       i_func,
    input  logic [1:0]       i_key_code,
    input  logic [4:0]       i_rtc_hour,
    input  logic [5:0]       i_rtc_minute,
    input  logic [5:0]       i_rtc_second,
    input  logic [6:0]       i_temp_reading,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_result          o_result
);

    logic [7:0]  r_scan_div,   n_scan_div;
    logic [9:0]  r_blink_scans, n_blink_scans;
    logic [15:0] r_alarm_half, n_alarm_half;
    logic [7:0]  r_alarm_togs, n_alarm_togs;
    logic [1:0]  r_clock_field, n_clock_field;
    logic [1:0]  r_alarm_field, n_alarm_field;
    logic        r_temp_view,  n_temp_view;
    logic [2:0]  r_held_key,   n_held_key;
    t_time       r_edit_time,  n_edit_time;
    t_time       r_alarm_time, n_alarm_time;
    t_time       r_now_time,   n_now_time;
    logic [6:0]  r_temp_value, n_temp_value;
    logic [7:0]  r_scan_tick,  n_scan_tick;
    logic [9:0]  r_scan_count, n_scan_count;
    logic        r_blink_on,   n_blink_on;
    logic [2:0]  r_digit_pos,  n_digit_pos;
    logic        r_alarm_act,  n_alarm_act;
    logic [15:0] r_alarm_tick, n_alarm_tick;
    logic [7:0]  r_alarm_cnt,  n_alarm_cnt;
    logic        r_alarm_ph,   n_alarm_ph;
    logic        r_led,        n_led;

    t_disp_ctx   w_ctx;
    logic [7:0]  w_segs;
    logic [1:0]  w_key;
    logic [1:0]  w_fsel;
    logic [1:0]  w_fi;
    logic [5:0]  w_top;
    logic [5:0]  w_cur;
    logic [5:0]  w_adj;
    logic        w_up;

    assign w_ctx.clock_field = r_clock_field;
    assign w_ctx.alarm_field = r_alarm_field;
    assign w_ctx.temp_view   = r_temp_view;
    assign w_ctx.blink_on    = n_blink_on;
    assign w_ctx.edit_time   = r_edit_time;
    assign w_ctx.alarm_time  = r_alarm_time;
    assign w_ctx.now_time    = r_now_time;
    assign w_ctx.temp_value  = r_temp_value;
    assign w_ctx.pos         = r_digit_pos;

    acs_disp u_disp (
        .i_ctx      (w_ctx),
        .o_segments (w_segs)
    );

    // Field being adjusted by the up and down keys and its bounded new value.
    assign w_key  = r_held_key[1:0] - 2'd1;
    assign w_up   = (w_key == KEY_UP);
    assign w_fsel = (r_clock_field != FLD_NONE) ? r_clock_field : r_alarm_field;
    assign w_fi   = w_fsel - 2'd1;
    assign w_top  = (w_fsel == FLD_HOUR) ? HOUR_MAX : MIN_MAX;
    assign w_cur  = (r_clock_field != FLD_NONE) ? r_edit_time[w_fi] : r_alarm_time[w_fi];
    assign w_adj  = w_up ? ((w_cur < w_top) ? w_cur + 6'd1 : w_cur)
                         : ((w_cur != 6'd0) ? w_cur - 6'd1 : w_cur);

    always_comb begin
        n_scan_div    = r_scan_div;
        n_blink_scans = r_blink_scans;
        n_alarm_half  = r_alarm_half;
        n_alarm_togs  = r_alarm_togs;
        n_clock_field = r_clock_field;
        n_alarm_field = r_alarm_field;
        n_temp_view   = r_temp_view;
        n_held_key    = r_held_key;
        n_edit_time   = r_edit_time;
        n_alarm_time  = r_alarm_time;
        n_now_time    = r_now_time;
        n_temp_value  = r_temp_value;
        n_scan_tick   = r_scan_tick;
        n_scan_count  = r_scan_count;
        n_blink_on    = r_blink_on;
        n_digit_pos   = r_digit_pos;
        n_alarm_act   = r_alarm_act;
        n_alarm_tick  = r_alarm_tick;
        n_alarm_cnt   = r_alarm_cnt;
        n_alarm_ph    = r_alarm_ph;
        n_led         = r_led;
        o_result      = '0;
        o_result.segments = SEG_BLANK;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCAN_DIV:   n_scan_div    = i_cfg_data[7:0];
                CFG_BLINK:      n_blink_scans = i_cfg_data[9:0];
                CFG_ALARM_HALF: n_alarm_half  = i_cfg_data[15:0];
                default:        n_alarm_togs  = i_cfg_data[7:0];
            endcase
        end

        if (i_accept) begin
            priority case (i_func)
                FN_TICK: begin
                    n_scan_tick = r_scan_tick + 8'd1;
                    if (n_scan_tick >= r_scan_div) begin
                        n_scan_tick  = 8'd0;
                        n_scan_count = r_scan_count + 10'd1;
                        if (n_scan_count >= r_blink_scans) begin
                            n_scan_count = 10'd0;
                            n_blink_on   = ~r_blink_on;
                        end
                        o_result.scan_valid  = 1'b1;
                        o_result.digit_index = r_digit_pos;
                        o_result.segments    = w_segs;
                        n_digit_pos          = r_digit_pos + 3'd1;
                    end
                    if (r_alarm_act) begin
                        n_alarm_tick = r_alarm_tick + 16'd1;
                        if (n_alarm_tick >= r_alarm_half) begin
                            n_alarm_tick = 16'd0;
                            n_led        = r_alarm_ph;
                            n_alarm_ph   = ~r_alarm_ph;
                            n_alarm_cnt  = r_alarm_cnt + 8'd1;
                            if (n_alarm_cnt >= r_alarm_togs) begin
                                n_alarm_cnt = 8'd0;
                                n_alarm_act = 1'b0;
                                n_led       = 1'b0;
                            end
                        end
                    end
                end
                FN_PRESS: begin
                    if (r_held_key == 3'd0) begin
                        n_held_key = {1'b0, i_key_code} + 3'd1;
                        if (r_clock_field == FLD_NONE && r_alarm_field == FLD_NONE
                            && i_key_code == KEY_DOWN) begin
                            n_temp_view = 1'b1;
                        end
                    end
                end
                FN_RELEASE: begin
                    if (r_held_key != 3'd0) begin
                        if (r_temp_view) begin
                            n_temp_view = 1'b0;
                            n_alarm_act = 1'b0;
                            n_led       = 1'b0;
                        end else if (r_alarm_act) begin
                            n_alarm_act = 1'b0;
                            n_led       = 1'b0;
                        end else if (w_key == KEY_SET_CLOCK) begin
                            if (r_alarm_field == FLD_NONE) begin
                                if (r_clock_field != FLD_SECOND) begin
                                    n_clock_field = r_clock_field + 2'd1;
                                end else begin
                                    // Leaving clock set commits the edited time.
                                    n_clock_field       = FLD_NONE;
                                    o_result.rtc_write  = 1'b1;
                                    o_result.new_hour   = r_edit_time[0][4:0];
                                    o_result.new_minute = r_edit_time[1];
                                    o_result.new_second = r_edit_time[2];
                                    n_now_time          = r_edit_time;
                                end
                            end
                        end else if (w_key == KEY_SET_ALARM) begin
                            if (r_clock_field == FLD_NONE) begin
                                n_alarm_field = r_alarm_field + 2'd1;
                            end
                        end else if (r_clock_field != FLD_NONE) begin
                            n_edit_time[w_fi] = w_adj;
                        end else if (r_alarm_field != FLD_NONE) begin
                            n_alarm_time[w_fi] = w_adj;
                        end
                        n_held_key = 3'd0;
                    end
                end
                FN_RTC: begin
                    n_now_time[0] = {1'b0, i_rtc_hour};
                    n_now_time[1] = i_rtc_minute;
                    n_now_time[2] = i_rtc_second;
                    if (n_now_time == r_alarm_time) begin
                        n_alarm_act = 1'b1;
                        n_alarm_cnt = 8'd0;
                    end
                end
                FN_TEMP: begin
                    n_temp_value = i_temp_reading;
                end
                default: begin
                end
            endcase
            o_result.alarm_led = n_led;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_div    <= 8'd20;
            r_blink_scans <= 10'd500;
            r_alarm_half  <= 16'd2000;
            r_alarm_togs  <= 8'd25;
            r_clock_field <= FLD_NONE;
            r_alarm_field <= FLD_NONE;
            r_temp_view   <= 1'b0;
            r_held_key    <= 3'd0;
            r_edit_time   <= '0;
            r_alarm_time  <= '0;
            r_now_time    <= '0;
            r_temp_value  <= 7'd0;
            r_scan_tick   <= 8'd0;
            r_scan_count  <= 10'd0;
            r_blink_on    <= 1'b1;
            r_digit_pos   <= 3'd0;
            r_alarm_act   <= 1'b0;
            r_alarm_tick  <= 16'd0;
            r_alarm_cnt   <= 8'd0;
            r_alarm_ph    <= 1'b1;
            r_led         <= 1'b0;
        end else begin
            r_scan_div    <= n_scan_div;
            r_blink_scans <= n_blink_scans;
            r_alarm_half  <= n_alarm_half;
            r_alarm_togs  <= n_alarm_togs;
            r_clock_field <= n_clock_field;
            r_alarm_field <= n_alarm_field;
            r_temp_view   <= n_temp_view;
            r_held_key    <= n_held_key;
            r_edit_time   <= n_edit_time;
            r_alarm_time  <= n_alarm_time;
            r_now_time    <= n_now_time;
            r_temp_value  <= n_temp_value;
            r_scan_tick   <= n_scan_tick;
            r_scan_count  <= n_scan_count;
            r_blink_on    <= n_blink_on;
            r_digit_pos   <= n_digit_pos;
            r_alarm_act   <= n_alarm_act;
            r_alarm_tick  <= n_alarm_tick;
            r_alarm_cnt   <= n_alarm_cnt;
            r_alarm_ph    <= n_alarm_ph;
            r_led         <= n_led;
        end
    end

endmodule

>>> tb/alarm_clock_set_and_display_tb.sv
// Testbench for the alarm clock controller: directed and random events against a predictor.
`timescale 1ns / 100ps

module alarm_clock_set_and_display_tb;
    import acs_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    acs_in_if ev_ch ();
    acs_out_if res_ch ();

    alarm_clock_set_and_display dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(ev_ch.sink), .o_out(res_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    typedef struct {
        logic [2:0] func;
        logic [1:0] key_code;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [6:0] temp;
    } t_event;

    // Predictor state.
    logic [7:0] m_scan_div;
    logic [9:0] m_blink_len;
    logic [15:0] m_half;
    logic [7:0] m_togs;
    logic [1:0] m_clk_fld, m_alm_fld;
    logic m_temp_view;
    logic [2:0] m_held;
    logic [5:0] m_edit [3];
    logic [5:0] m_alarm [3];
    logic [5:0] m_now [3];
    logic [6:0] m_temp;
    logic [7:0] m_scan_tick;
    logic [9:0] m_scan_cnt;
    logic m_blink_on;
    logic [2:0] m_pos;
    logic m_alm_on;
    logic [15:0] m_alm_tick;
    logic [7:0] m_alm_cnt;
    logic m_alm_phase, m_led;

    t_result expected_results[$];
    bit failed;
    int idle_cycles;

    function automatic logic [7:0] digit_seg(input int d);
        case (d)
            0: return 8'hc0;
            1: return 8'hf9;
            2: return 8'ha4;
            3: return 8'hb0;
            4: return 8'h99;
            5: return 8'h92;
            6: return 8'h82;
            7: return 8'hf8;
            8: return 8'h80;
            default: return 8'h90;
        endcase
    endfunction

    function automatic logic [7:0] time_seg(input int t0, input int t1, input int t2,
                                            input int p);
        int v;
        if (p == 2 || p == 5) return SEG_DASH;
        v = (p / 3 == 0) ? t0 : (p / 3 == 1) ? t1 : t2;
        return (p % 3 == 0) ? digit_seg((v / 10) % 10) : digit_seg(v % 10);
    endfunction

    function automatic logic [7:0] shown_seg(input int p);
        int fld;
        int t;
        fld = (m_clk_fld != FLD_NONE) ? m_clk_fld : m_alm_fld;
        if (fld != 0 && m_blink_on && p / 3 == fld - 1 && p % 3 != 2) return SEG_BLANK;
        if (m_clk_fld != FLD_NONE) return time_seg(m_edit[0], m_edit[1], m_edit[2], p);
        if (m_alm_fld != FLD_NONE) return time_seg(m_alarm[0], m_alarm[1], m_alarm[2], p);
        if (m_temp_view) begin
            t = (m_temp > 99) ? 99 : m_temp;
            if (p == 5) return digit_seg(t / 10);
            if (p == 6) return digit_seg(t % 10);
            if (p == 7) return SEG_C;
            return SEG_BLANK;
        end
        return time_seg(m_now[0], m_now[1], m_now[2], p);
    endfunction

    function automatic void nudge_field(inout logic [5:0] t [3], input logic [1:0] fld,
                                        input bit up);
        int i;
        int top;
        i = (fld - 1) % 3;
        top = (fld == FLD_HOUR) ? 23 : 59;
        if (up) begin
            if (t[i] < top) t[i]++;
        end else if (t[i] != 0) begin
            t[i]--;
        end
    endfunction

    task automatic model_reset();
        m_scan_div = 20; m_blink_len = 500; m_half = 2000; m_togs = 25;
        m_clk_fld = FLD_NONE; m_alm_fld = FLD_NONE; m_temp_view = 0; m_held = 0;
        for (int i = 0; i < 3; i++) begin
            m_edit[i] = 0; m_alarm[i] = 0; m_now[i] = 0;
        end
        m_temp = 0; m_scan_tick = 0; m_scan_cnt = 0; m_blink_on = 1; m_pos = 0;
        m_alm_on = 0; m_alm_tick = 0; m_alm_cnt = 0; m_alm_phase = 1; m_led = 0;
    endtask

    function automatic t_result predict_event(input t_event e);
        t_result r;
        logic [1:0] k;
        r = '0;
        r.segments = SEG_BLANK;
        case (e.func)
            FN_TICK: begin
                m_scan_tick = m_scan_tick + 1;
                if (m_scan_tick >= m_scan_div) begin
                    m_scan_tick = 0;
                    m_scan_cnt = m_scan_cnt + 1;
                    if (m_scan_cnt >= m_blink_len) begin
                        m_scan_cnt = 0;
                        m_blink_on = ~m_blink_on;
                    end
                    r.scan_valid = 1;
                    r.digit_index = m_pos;
                    r.segments = shown_seg(m_pos);
                    m_pos = m_pos + 1;
                end
                if (m_alm_on) begin
                    m_alm_tick = m_alm_tick + 1;
                    if (m_alm_tick >= m_half) begin
                        m_alm_tick = 0;
                        m_led = m_alm_phase;
                        m_alm_phase = ~m_alm_phase;
                        m_alm_cnt = m_alm_cnt + 1;
                        if (m_alm_cnt >= m_togs) begin
                            m_alm_cnt = 0; m_alm_on = 0; m_led = 0;
                        end
                    end
                end
            end
            FN_PRESS: begin
                if (m_held == 0) begin
                    m_held = e.key_code + 1;
                    if (m_clk_fld == FLD_NONE && m_alm_fld == FLD_NONE && e.key_code == KEY_DOWN)
                        m_temp_view = 1;
                end
            end
            FN_RELEASE: begin
                if (m_held != 0) begin
                    k = m_held - 1;
                    if (m_temp_view) begin
                        m_temp_view = 0; m_alm_on = 0; m_led = 0;
                    end else if (m_alm_on) begin
                        m_alm_on = 0; m_led = 0;
                    end else if (k == KEY_SET_CLOCK) begin
                        if (m_alm_fld == FLD_NONE) begin
                            if (m_clk_fld != FLD_SECOND) begin
                                m_clk_fld = m_clk_fld + 1;
                            end else begin
                                m_clk_fld = FLD_NONE;
                                r.rtc_write = 1;
                                r.new_hour = m_edit[0][4:0];
                                r.new_minute = m_edit[1];
                                r.new_second = m_edit[2];
                                for (int i = 0; i < 3; i++) m_now[i] = m_edit[i];
                            end
                        end
                    end else if (k == KEY_SET_ALARM) begin
                        if (m_clk_fld == FLD_NONE) m_alm_fld = m_alm_fld + 1;
                    end else if (m_clk_fld != FLD_NONE) begin
                        nudge_field(m_edit, m_clk_fld, k == KEY_UP);
                    end else if (m_alm_fld != FLD_NONE) begin
                        nudge_field(m_alarm, m_alm_fld, k == KEY_UP);
                    end
                    m_held = 0;
                end
            end
            FN_RTC: begin
                m_now[0] = e.hour; m_now[1] = e.minute; m_now[2] = e.second;
                if (m_now[0] == m_alarm[0] && m_now[1] == m_alarm[1] && m_now[2] == m_alarm[2])
                begin
                    m_alm_on = 1; m_alm_cnt = 0;
                end
            end
            FN_TEMP: m_temp = e.temp;
            default: ;
        endcase
        r.alarm_led = m_led;
        return r;
    endfunction

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Result checker with random stalls on the output side.
    initial begin
        t_result got, want;
        int stall;
        res_ch.ready = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0) stall = 0;
            repeat (stall) @(negedge i_clk);
            res_ch.ready = 1;
            do @(posedge i_clk); while (!res_ch.valid);
            got.scan_valid = res_ch.scan_valid;
            got.digit_index = res_ch.digit_index;
            got.segments = res_ch.segments;
            got.alarm_led = res_ch.alarm_led;
            got.rtc_write = res_ch.rtc_write;
            got.new_hour = res_ch.new_hour;
            got.new_minute = res_ch.new_minute;
            got.new_second = res_ch.new_second;
            @(negedge i_clk);
            res_ch.ready = 0;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                failed = 1;
            end else begin
                want = expected_results.pop_front();
                if (got.scan_valid !== want.scan_valid)
                    $display("%0t: scan_valid expected %0d actual %0d", $time,
                             want.scan_valid, got.scan_valid);
                if (got.digit_index !== want.digit_index)
                    $display("%0t: digit_index expected %0d actual %0d", $time,
                             want.digit_index, got.digit_index);
                if (got.segments !== want.segments)
                    $display("%0t: segments expected %h actual %h", $time,
                             want.segments, got.segments);
                if (got.alarm_led !== want.alarm_led)
                    $display("%0t: alarm_led expected %0d actual %0d", $time,
                             want.alarm_led, got.alarm_led);
                if (got.rtc_write !== want.rtc_write)
                    $display("%0t: rtc_write expected %0d actual %0d", $time,
                             want.rtc_write, got.rtc_write);
                if (got.new_hour !== want.new_hour)
                    $display("%0t: new_hour expected %0d actual %0d", $time,
                             want.new_hour, got.new_hour);
                if (got.new_minute !== want.new_minute)
                    $display("%0t: new_minute expected %0d actual %0d", $time,
                             want.new_minute, got.new_minute);
                if (got.new_second !== want.new_second)
                    $display("%0t: new_second expected %0d actual %0d", $time,
                             want.new_second, got.new_second);
                if (got !== want) failed = 1;
            end
        end
    end

    // Watchdog on cycles without any accepted item or result.
    always @(posedge i_clk) begin
        if ((ev_ch.valid && ev_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_event(input t_event e, input bit no_gap = 0);
        if (!no_gap) repeat ($urandom_range(0, 6)) @(negedge i_clk);
        ev_ch.valid = 1;
        ev_ch.func = e.func;
        ev_ch.key_code = e.key_code;
        ev_ch.rtc_hour = e.hour;
        ev_ch.rtc_minute = e.minute;
        ev_ch.rtc_second = e.second;
        ev_ch.temp_reading = e.temp;
        do @(posedge i_clk); while (!ev_ch.ready);
        expected_results.push_back(predict_event(e));
        @(negedge i_clk);
        ev_ch.valid = 0;
    endtask

    task automatic send_simple(input logic [2:0] f, input logic [1:0] k = KEY_SET_CLOCK);
        t_event e;
        e = '{f, k, 0, 0, 0, 0};
        send_event(e);
    endtask

    task automatic tap_key(input logic [1:0] k);
        send_simple(FN_PRESS, k);
        send_simple(FN_RELEASE, k);
    endtask

    task automatic send_rtc(input int h, input int mi, input int s);
        t_event e;
        e = '{FN_RTC, $urandom_range(0, 3), h, mi, s, $urandom_range(0, 127)};
        send_event(e);
    endtask

    task automatic drain();
        wait (expected_results.size() == 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int val);
        drain();
        i_cfg_we = 1; i_cfg_idx = idx; i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 0;
        case (idx)
            CFG_SCAN_DIV: m_scan_div = val;
            CFG_BLINK: m_blink_len = val;
            CFG_ALARM_HALF: m_half = val;
            default: m_togs = val;
        endcase
    endtask

    task automatic test_clock_setting();
        tap_key(KEY_SET_CLOCK);
        repeat (25) tap_key(KEY_UP);
        send_simple(FN_TICK);
        tap_key(KEY_SET_CLOCK);
        repeat (61) tap_key(KEY_UP);
        tap_key(KEY_DOWN);
        tap_key(KEY_SET_CLOCK);
        repeat (3) tap_key(KEY_DOWN);
        tap_key(KEY_SET_CLOCK);
        repeat (6) send_simple(FN_TICK);
    endtask

    task automatic test_alarm_and_temp();
        t_event e;
        tap_key(KEY_SET_ALARM);
        repeat (2) tap_key(KEY_UP);
        tap_key(KEY_SET_ALARM);
        tap_key(KEY_UP);
        tap_key(KEY_SET_ALARM);
        tap_key(KEY_SET_ALARM);
        send_rtc(31, 63, 63);
        send_rtc(2, 1, 0);
        repeat (12) send_simple(FN_TICK);
        e = '{FN_TEMP, 0, 0, 0, 0, 127};
        send_event(e);
        tap_key(KEY_DOWN);
        send_simple(FN_PRESS, KEY_DOWN);
        repeat (8) send_simple(FN_TICK);
        send_simple(FN_RELEASE, KEY_DOWN);
        send_simple(3'd5);
        send_simple(3'd7);
    endtask

    task automatic test_random(input int count);
        t_event e;
        for (int n = 0; n < count; n++) begin
            e.func = FN_TICK;
            e.key_code = $urandom_range(0, 3);
            e.hour = $urandom_range(0, 31);
            e.minute = $urandom_range(0, 63);
            e.second = $urandom_range(0, 63);
            e.temp = $urandom_range(0, 127);
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7: e.func = FN_TICK;
                8, 9, 10: e.func = FN_PRESS;
                11, 12, 13: e.func = FN_RELEASE;
                14, 15: begin
                    e.func = FN_RTC;
                    // Aim mostly at the alarm time so the flasher runs often.
                    if ($urandom_range(0, 2) != 0) begin
                        e.hour = m_alarm[0]; e.minute = m_alarm[1]; e.second = m_alarm[2];
                    end
                end
                16, 17: e.func = FN_TEMP;
                18: e.func = $urandom_range(5, 7);
                default: e.func = FN_TICK;
            endcase
            send_event(e, n % 50 < 10);
        end
    endtask

    initial begin
        failed = 0;
        idle_cycles = 0;
        i_rst_n = 0;
        i_cfg_we = 0; i_cfg_idx = CFG_SCAN_DIV; i_cfg_data = 0;
        ev_ch.valid = 0; ev_ch.func = FN_TICK; ev_ch.key_code = 0; ev_ch.rtc_hour = 0;
        ev_ch.rtc_minute = 0; ev_ch.rtc_second = 0; ev_ch.temp_reading = 0;
        model_reset();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;

        write_reg(CFG_SCAN_DIV, 1);
        write_reg(CFG_BLINK, 3);
        write_reg(CFG_ALARM_HALF, 2);
        write_reg(CFG_ALARM_TOGS, 4);
        test_clock_setting();
        test_alarm_and_temp();
        test_random(100);
        drain();
        write_reg(CFG_SCAN_DIV, 0);
        write_reg(CFG_BLINK, 0);
        write_reg(CFG_ALARM_HALF, 0);
        write_reg(CFG_ALARM_TOGS, 0);
        test_random(100);
        write_reg(CFG_SCAN_DIV, 255);
        write_reg(CFG_BLINK, 1023);
        write_reg(CFG_ALARM_HALF, 65535);
        write_reg(CFG_ALARM_TOGS, 255);
        test_random(60);
        write_reg(CFG_SCAN_DIV, 2);
        write_reg(CFG_BLINK, 1);
        write_reg(CFG_ALARM_HALF, 1);
        write_reg(CFG_ALARM_TOGS, 1);
        test_random(150);

        drain();
        repeat (10) @(negedge i_clk);
        if (!failed && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
